### rtl/core/rtsf_pkg.sv
package rtsf_pkg;

    localparam int unsigned S_DATA_W = 104;
    localparam int unsigned S_USER_W = 1;
    localparam int unsigned M_DATA_W = 40;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned JUMP_CNT_W = 4;

    localparam logic [31:0] MIN_EPOCH_RST = 32'd1704067200;
    localparam logic [31:0] MAX_EPOCH_RST = 32'd4102444799;
    localparam logic [7:0] PAIR_TOL_RST = 8'd1;
    localparam logic [15:0] JUMP_LIMIT_RST = 16'd5;
    localparam logic [JUMP_CNT_W-1:0] JUMP_ACCEPT_RST = 4'd3;
    localparam logic [JUMP_CNT_W-1:0] JUMP_CNT_MAX = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_EPOCH   = 3'd0,
        REG_MAX_EPOCH   = 3'd1,
        REG_PAIR_TOL    = 3'd2,
        REG_JUMP_LIMIT  = 3'd3,
        REG_JUMP_ACCEPT = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_FRESH     = 3'd0,
        ST_JUMP_OK   = 3'd1,
        ST_LAST_GOOD = 3'd2,
        ST_READ2     = 3'd3,
        ST_NONE      = 3'd4,
        ST_SET       = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CA_NONE     = 3'd0,
        CA_INVALID  = 3'd1,
        CA_MISMATCH = 3'd2,
        CA_RANGE    = 3'd3,
        CA_JUMP     = 3'd4
    } cause_t;

    typedef struct packed {
        logic [31:0]           min_epoch;
        logic [31:0]           max_epoch;
        logic [7:0]            pair_tol;
        logic [15:0]           jump_limit;
        logic [JUMP_CNT_W-1:0] jump_accept;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic        rtc_present;
        logic        read1_valid;
        logic [31:0] read1_seconds;
        logic        read2_valid;
        logic [31:0] read2_seconds;
        logic        set_valid;
        logic [31:0] set_seconds;
    } item_t;

    typedef struct packed {
        logic        time_valid;
        logic [31:0] time_seconds;
        status_t     status;
        cause_t      cause;
    } result_t;

endpackage

### rtl/core/rtsf_cfg.sv
module rtsf_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rtsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtsf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rtsf_pkg::cfg_t                   cfg
);
    import rtsf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MIN_EPOCH:   cfg_next.min_epoch = cfg_data;
                REG_MAX_EPOCH:   cfg_next.max_epoch = cfg_data;
                REG_PAIR_TOL:    cfg_next.pair_tol = cfg_data[7:0];
                REG_JUMP_LIMIT:  cfg_next.jump_limit = cfg_data[15:0];
                REG_JUMP_ACCEPT: cfg_next.jump_accept = cfg_data[JUMP_CNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_epoch <= MIN_EPOCH_RST;
            cfg_reg.max_epoch <= MAX_EPOCH_RST;
            cfg_reg.pair_tol <= PAIR_TOL_RST;
            cfg_reg.jump_limit <= JUMP_LIMIT_RST;
            cfg_reg.jump_accept <= JUMP_ACCEPT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/rtsf_check.sv
module rtsf_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              upd,
    input  rtsf_pkg::item_t   item,
    input  rtsf_pkg::cfg_t    cfg,
    output rtsf_pkg::result_t res
);
    import rtsf_pkg::*;

    logic [31:0]           lg_time_reg;
    logic [31:0]           lg_time_next;
    logic                  lg_flag_reg;
    logic                  lg_flag_next;
    logic [JUMP_CNT_W-1:0] jump_cnt_reg;
    logic [JUMP_CNT_W-1:0] jump_cnt_next;

    logic                  fb_usable;
    logic                  pair_bad;
    logic                  range_bad;
    logic                  jump_big;
    logic [JUMP_CNT_W-1:0] jump_cnt_inc;
    logic [31:0]           pair_diff;
    logic [31:0]           jump_diff;

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    assign pair_diff = abs_diff(item.read1_seconds, item.read2_seconds);
    assign jump_diff = abs_diff(item.read2_seconds, lg_time_reg);
    assign fb_usable = lg_flag_reg && (lg_time_reg >= cfg.min_epoch);
    assign pair_bad = pair_diff > {24'd0, cfg.pair_tol};
    assign range_bad = (item.read2_seconds < cfg.min_epoch)
                    || (item.read2_seconds > cfg.max_epoch);
    assign jump_big = jump_diff > {16'd0, cfg.jump_limit};
    assign jump_cnt_inc = (jump_cnt_reg == JUMP_CNT_MAX) ? jump_cnt_reg
                                                         : jump_cnt_reg + 4'd1;

    always_comb
    begin
        lg_time_next = lg_time_reg;
        lg_flag_next = lg_flag_reg;
        jump_cnt_next = jump_cnt_reg;
        res.time_valid = 1'b0;
        res.time_seconds = 32'd0;
        res.status = ST_NONE;
        res.cause = CA_NONE;
        priority if (item.mode)
        begin
            lg_time_next = item.set_seconds;
            lg_flag_next = item.set_valid;
            res.time_valid = item.set_valid;
            res.time_seconds = item.set_valid ? item.set_seconds : 32'd0;
            res.status = ST_SET;
        end
        else if (!item.rtc_present)
        begin
            res.status = ST_NONE;
        end
        else if (!item.read1_valid || !item.read2_valid || (!pair_bad && range_bad))
        begin
            res.cause = (!item.read1_valid || !item.read2_valid) ? CA_INVALID : CA_RANGE;
            if (fb_usable)
            begin
                res.time_valid = 1'b1;
                res.time_seconds = lg_time_reg;
                res.status = ST_LAST_GOOD;
            end
        end
        else if (pair_bad)
        begin
            res.cause = CA_MISMATCH;
            res.time_valid = 1'b1;
            res.time_seconds = fb_usable ? lg_time_reg : item.read2_seconds;
            res.status = fb_usable ? ST_LAST_GOOD : ST_READ2;
        end
        else if (fb_usable && jump_big && (jump_cnt_inc < cfg.jump_accept))
        begin
            jump_cnt_next = jump_cnt_inc;
            res.time_valid = 1'b1;
            res.time_seconds = lg_time_reg;
            res.status = ST_LAST_GOOD;
            res.cause = CA_JUMP;
        end
        else
        begin
            // Fresh time, or a jump that has been seen often enough to be believed.
            if (fb_usable)
            begin
                jump_cnt_next = '0;
            end
            lg_time_next = item.read2_seconds;
            lg_flag_next = 1'b1;
            res.time_valid = 1'b1;
            res.time_seconds = item.read2_seconds;
            res.status = (fb_usable && jump_big) ? ST_JUMP_OK : ST_FRESH;
            res.cause = (fb_usable && jump_big) ? CA_JUMP : CA_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lg_time_reg <= 32'd0;
            lg_flag_reg <= 1'b0;
            jump_cnt_reg <= '0;
        end
        else if (upd)
        begin
            lg_time_reg <= lg_time_next;
            lg_flag_reg <= lg_flag_next;
            jump_cnt_reg <= jump_cnt_next;
        end
    end

    a_fresh_stores: assert property (@(posedge clk) disable iff (!rst_n)
        upd && !item.mode && (res.status == ST_FRESH || res.status == ST_JUMP_OK)
        |=> lg_flag_reg && (lg_time_reg == $past(item.read2_seconds)))
        else $error("Accepted reading was not stored as the last good time.");

    a_fallback_holds: assert property (@(posedge clk) disable iff (!rst_n)
        upd && !item.mode && res.status == ST_LAST_GOOD |=> $stable(lg_time_reg))
        else $error("Last good time changed on a fallback result.");

    a_jump_clears: assert property (@(posedge clk) disable iff (!rst_n)
        upd && res.status == ST_JUMP_OK |=> jump_cnt_reg == '0)
        else $error("Jump count not cleared after an accepted jump.");

    a_set_echo: assert property (@(posedge clk) disable iff (!rst_n)
        upd && item.mode |=> (lg_flag_reg == $past(item.set_valid))
                             && (jump_cnt_reg == $past(jump_cnt_reg)))
        else $error("Force set did not load the flag or disturbed the jump count.");

endmodule

### rtl/core/rtc_timestamp_sanity_filter_unit.sv
// Timestamp sanity filter. Each input transfer either qualifies a pair of back-to-back clock
// readings or force-sets the last good time, and produces exactly one result transfer.
// The block takes one item per cycle unless the output stalls; each result passes through the
// input register, then the result register, and the checks plus the update of the last good
// time and jump count all happen combinationally between those two registers, which is
// what lets the next item see the updated state immediately. Configuration writes are taken
// every cycle and must only be issued while no item is in flight.
module rtc_timestamp_sanity_filter_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rtc_present, read1_valid, read1_seconds, read2_valid, read2_seconds, set_valid,
    // set_seconds, zero fill
    input  logic [rtsf_pkg::S_DATA_W-1:0]    s_tdata,
    // mode
    input  logic [rtsf_pkg::S_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // time_valid, time_seconds, status, cause, zero fill
    output logic [rtsf_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rtsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rtsf_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    item_t   in_item_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    s_fire;

    assign in_item_next.mode = s_tuser[0];
    assign in_item_next.rtc_present = s_tdata[0];
    assign in_item_next.read1_valid = s_tdata[1];
    assign in_item_next.read1_seconds = s_tdata[33:2];
    assign in_item_next.read2_valid = s_tdata[34];
    assign in_item_next.read2_seconds = s_tdata[66:35];
    assign in_item_next.set_valid = s_tdata[67];
    assign in_item_next.set_seconds = s_tdata[99:68];

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire = s_tvalid && s_tready;
    assign in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    rtsf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtsf_check u_check (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= in_item_next;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, out_res_reg.cause, out_res_reg.status,
                      out_res_reg.time_seconds, out_res_reg.time_valid};

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("Input stalled without a full pipeline.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("Processed item did not produce a result transfer.");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |-> !advance)
        else $error("Pending result overwritten.");

endmodule

### test/rtc_timestamp_sanity_filter_unit_tb.sv
`timescale 1ns / 1ps

module rtc_timestamp_sanity_filter_unit_tb;

    import rtsf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS = 310;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [31:0] FORCED_BASE = 32'd1800000000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [31:0]           min_epoch;
    logic [31:0]           max_epoch;
    logic [7:0]            pair_tol;
    logic [15:0]           jump_limit;
    logic [JUMP_CNT_W-1:0] jump_accept;

    logic [31:0]           good_time;
    logic                  good_flag;
    logic [JUMP_CNT_W-1:0] jump_count;

    result_t pending_outcomes[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    int      rx_gap = 0;
    int      rx_hold = 0;
    int      burst_left = 0;
    logic    tx_quiet = 1'b0;
    logic    rx_quiet = 1'b0;

    rtc_timestamp_sanity_filter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] seconds_apart(logic [31:0] a, logic [31:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic result_t make_outcome(logic valid, logic [31:0] t, status_t st, cause_t ca);
        result_t r;
        r.time_valid = valid;
        r.time_seconds = valid ? t : 32'd0;
        r.status = st;
        r.cause = ca;
        return r;
    endfunction

    function automatic result_t qualify_timestamp(item_t it);
        logic usable;
        usable = good_flag && (good_time >= min_epoch);
        if (it.mode)
        begin
            good_time = it.set_seconds;
            good_flag = it.set_valid;
            return make_outcome(it.set_valid, it.set_seconds, ST_SET, CA_NONE);
        end
        if (!it.rtc_present)
            return make_outcome(1'b0, 32'd0, ST_NONE, CA_NONE);
        if (!it.read1_valid || !it.read2_valid)
            return usable ? make_outcome(1'b1, good_time, ST_LAST_GOOD, CA_INVALID)
                          : make_outcome(1'b0, 32'd0, ST_NONE, CA_INVALID);
        if (seconds_apart(it.read1_seconds, it.read2_seconds) > 32'(pair_tol))
            return usable ? make_outcome(1'b1, good_time, ST_LAST_GOOD, CA_MISMATCH)
                          : make_outcome(1'b1, it.read2_seconds, ST_READ2, CA_MISMATCH);
        if (it.read2_seconds < min_epoch || it.read2_seconds > max_epoch)
            return usable ? make_outcome(1'b1, good_time, ST_LAST_GOOD, CA_RANGE)
                          : make_outcome(1'b0, 32'd0, ST_NONE, CA_RANGE);
        if (usable)
        begin
            if (seconds_apart(it.read2_seconds, good_time) > 32'(jump_limit))
            begin
                if (jump_count < JUMP_CNT_MAX)
                    jump_count = jump_count + 1'b1;
                if (jump_count < jump_accept)
                    return make_outcome(1'b1, good_time, ST_LAST_GOOD, CA_JUMP);
                jump_count = '0;
                good_time = it.read2_seconds;
                good_flag = 1'b1;
                return make_outcome(1'b1, it.read2_seconds, ST_JUMP_OK, CA_JUMP);
            end
            jump_count = '0;
        end
        good_time = it.read2_seconds;
        good_flag = 1'b1;
        return make_outcome(1'b1, it.read2_seconds, ST_FRESH, CA_NONE);
    endfunction

    function automatic item_t pair_item(logic present, logic r1v, logic [31:0] r1,
                                        logic r2v, logic [31:0] r2);
        item_t it;
        it.mode = 1'b0;
        it.rtc_present = present;
        it.read1_valid = r1v;
        it.read1_seconds = r1;
        it.read2_valid = r2v;
        it.read2_seconds = r2;
        it.set_valid = 1'($urandom_range(0, 1));
        it.set_seconds = $urandom;
        return it;
    endfunction

    function automatic item_t set_item(logic sv, logic [31:0] st);
        item_t it;
        it = pair_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                       1'($urandom_range(0, 1)), $urandom);
        it.mode = 1'b1;
        it.set_valid = sv;
        it.set_seconds = st;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned k;
        int unsigned sel;
        logic [31:0] base;
        logic [31:0] delta;
        logic [31:0] off;
        logic [31:0] r2;
        it = pair_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                       1'($urandom_range(0, 1)), $urandom);
        k = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            k = 100;
        end
        if (k < 6)
        begin
            it.mode = 1'b1;
            it.set_valid = 1'($urandom_range(0, 4) != 0);
            it.set_seconds = (k < 2) ? $urandom : $urandom_range(max_epoch, min_epoch);
            return it;
        end
        if (k < 12)
            return it;
        if (k == 12)
            burst_left = int'(jump_accept) + 1;
        it.rtc_present = (k >= 14);
        it.read1_valid = 1'b1;
        it.read2_valid = 1'b1;
        if (k >= 14 && k < 20)
        begin
            it.read1_valid = 1'($urandom_range(0, 1));
            it.read2_valid = it.read1_valid ? 1'b0 : 1'($urandom_range(0, 1));
        end
        base = (good_flag && $urandom_range(0, 7) != 0) ? good_time
                                                         : $urandom_range(max_epoch, min_epoch);
        sel = $urandom_range(0, 9);
        if (k == 100)
            delta = 32'(jump_limit) + 32'd1 + $urandom_range(0, 100);
        else if (sel < 5)
            delta = $urandom_range(0, 32'(jump_limit));
        else if (sel == 5)
            delta = 32'(jump_limit);
        else if (sel == 6)
            delta = 32'(jump_limit) + 32'd1;
        else if (sel == 7)
            delta = 32'(jump_limit) + 32'd1 + $urandom_range(0, 65535);
        else if (sel == 8)
            delta = $urandom;
        else
            delta = 32'd0;
        r2 = ($urandom_range(0, 1) != 0) ? base + delta : base - delta;
        if (k != 100 && $urandom_range(0, 15) == 0)
        begin
            case ($urandom_range(0, 3))
                0: r2 = min_epoch;
                1: r2 = max_epoch;
                2: r2 = min_epoch - 32'd1;
                default: r2 = max_epoch + 32'd1;
            endcase
        end
        sel = $urandom_range(0, 9);
        if (sel < 7)
            off = $urandom_range(0, 32'(pair_tol));
        else if (sel == 7)
            off = 32'(pair_tol) + 32'd1;
        else if (sel == 8)
            off = $urandom;
        else
            off = 32'd0;
        it.read2_seconds = r2;
        it.read1_seconds = ($urandom_range(0, 1) != 0) ? r2 + off : r2 - off;
        return it;
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {4'b0, it.set_seconds, it.set_valid, it.read2_seconds, it.read2_valid,
                    it.read1_seconds, it.read1_valid, it.rtc_present};
        do
            @(posedge clk);
        while (!s_tready);
        pending_outcomes.insert(pending_outcomes.size(), qualify_timestamp(it));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        stop_sending();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MIN_EPOCH:   min_epoch = value;
            REG_MAX_EPOCH:   max_epoch = value;
            REG_PAIR_TOL:    pair_tol = value[7:0];
            REG_JUMP_LIMIT:  jump_limit = value[15:0];
            REG_JUMP_ACCEPT: jump_accept = value[JUMP_CNT_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(logic [31:0] lo, logic [31:0] hi, logic [31:0] tol,
                                  logic [31:0] lim, logic [31:0] acc);
        wait_idle();
        write_reg(REG_MIN_EPOCH, lo);
        write_reg(REG_MAX_EPOCH, hi);
        write_reg(REG_PAIR_TOL, tol);
        write_reg(REG_JUMP_LIMIT, lim);
        write_reg(REG_JUMP_ACCEPT, acc);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 63) == 0)
                tx_quiet = ~tx_quiet;
            if ($urandom_range(0, 63) == 0)
                rx_quiet = ~rx_quiet;
            send_item(random_item());
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        burst_left = 0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic test_reset_state();
        send_item(pair_item(1'b0, 1'b1, ALL_ONES, 1'b1, ALL_ONES));
        send_item(pair_item(1'b1, 1'b0, MIN_EPOCH_RST, 1'b1, MIN_EPOCH_RST));
        send_item(pair_item(1'b1, 1'b1, 32'd0, 1'b1, ALL_ONES));
        send_item(pair_item(1'b1, 1'b1, 32'd0, 1'b1, 32'd0));
        send_item(pair_item(1'b1, 1'b1, MIN_EPOCH_RST, 1'b1, MIN_EPOCH_RST));
    endtask

    task automatic test_fallback_paths();
        send_item(pair_item(1'b1, 1'b1, MIN_EPOCH_RST + 10, 1'b0, MIN_EPOCH_RST + 10));
        send_item(pair_item(1'b1, 1'b1, MIN_EPOCH_RST + 1, 1'b1, MIN_EPOCH_RST + 3));
        send_item(pair_item(1'b1, 1'b1, MAX_EPOCH_RST, 1'b1, MAX_EPOCH_RST + 1));
        send_item(pair_item(1'b0, 1'b1, MIN_EPOCH_RST, 1'b1, MIN_EPOCH_RST));
    endtask

    task automatic test_jump_acceptance();
        send_item(set_item(1'b1, FORCED_BASE));
        send_item(pair_item(1'b1, 1'b1, FORCED_BASE + 4, 1'b1, FORCED_BASE + 5));
        repeat (3) send_item(pair_item(1'b1, 1'b1, FORCED_BASE + 11, 1'b1, FORCED_BASE + 11));
        send_item(pair_item(1'b1, 1'b1, FORCED_BASE + 5, 1'b1, FORCED_BASE + 5));
        send_item(pair_item(1'b1, 1'b1, FORCED_BASE + 12, 1'b1, FORCED_BASE + 12));
    endtask

    task automatic test_forced_time();
        send_item(set_item(1'b0, ALL_ONES));
        send_item(pair_item(1'b1, 1'b0, FORCED_BASE, 1'b0, FORCED_BASE));
        send_item(set_item(1'b1, MIN_EPOCH_RST - 1));
        send_item(pair_item(1'b1, 1'b1, MIN_EPOCH_RST, 1'b1, MIN_EPOCH_RST + 1));
        send_item(set_item(1'b1, ALL_ONES));
        send_item(set_item(1'b1, 32'd0));
        send_item(pair_item(1'b1, 1'b1, MIN_EPOCH_RST + 100, 1'b1, MIN_EPOCH_RST));
    endtask

    task automatic test_output_backpressure();
        wait_idle();
        rx_hold = 300;
        tx_quiet = 1'b1;
        repeat (60) send_item(random_item());
        tx_quiet = 1'b0;
        burst_left = 0;
    endtask

    task automatic test_wide_limits();
        write_all_regs(32'd0, ALL_ONES, 32'd255, 32'd65535, 32'd15);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_single_second_window();
        write_all_regs(FORCED_BASE, FORCED_BASE, 32'd0, 32'd0, 32'd1);
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_random_registers();
        logic [31:0] lo;
        write_all_regs($urandom, $urandom, $urandom, $urandom,
                       {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'($urandom_range(1, 15))});
        run_random(PHASE_ITEMS);
        lo = $urandom_range(32'h7000_0000, 0);
        write_all_regs(lo, lo + $urandom_range(32'h8000_0000, 100), $urandom_range(0, 8),
                       $urandom_range(0, 300), $urandom_range(1, 15));
        run_random(PHASE_ITEMS);
    endtask

    task automatic test_spare_registers();
        wait_idle();
        write_reg(REG_SPARE_5, $urandom);
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, ALL_ONES);
        write_all_regs(MIN_EPOCH_RST, MAX_EPOCH_RST, 32'(PAIR_TOL_RST), 32'(JUMP_LIMIT_RST),
                       32'(JUMP_ACCEPT_RST));
        run_random(PHASE_ITEMS);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (rx_gap > 0)
            begin
                m_tready <= 1'b0;
                rx_gap--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (m_tvalid && m_tready)
        begin
            rx_gap = rx_quiet ? 0 : $urandom_range(0, 10);
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected transfer", 32'(m_tdata), 32'd0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_tdata[0] !== want.time_valid)
                    report_mismatch("time_valid", 32'(m_tdata[0]), 32'(want.time_valid));
                if (m_tdata[32:1] !== want.time_seconds)
                    report_mismatch("time_seconds", m_tdata[32:1], want.time_seconds);
                if (m_tdata[35:33] !== want.status)
                    report_mismatch("status", 32'(m_tdata[35:33]), 32'(want.status));
                if (m_tdata[38:36] !== want.cause)
                    report_mismatch("cause", 32'(m_tdata[38:36]), 32'(want.cause));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_EPOCH;
        cfg_data = '0;
        min_epoch = MIN_EPOCH_RST;
        max_epoch = MAX_EPOCH_RST;
        pair_tol = PAIR_TOL_RST;
        jump_limit = JUMP_LIMIT_RST;
        jump_accept = JUMP_ACCEPT_RST;
        good_time = '0;
        good_flag = 1'b0;
        jump_count = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_fallback_paths();
        test_jump_acceptance();
        test_forced_time();
        run_random(PHASE_ITEMS);
        test_output_backpressure();
        test_wide_limits();
        test_single_second_window();
        test_random_registers();
        test_spare_registers();

        stop_sending();
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rtsf_pkg.sv
rtl/core/rtsf_cfg.sv
rtl/core/rtsf_check.sv
rtl/core/rtc_timestamp_sanity_filter_unit.sv
test/rtc_timestamp_sanity_filter_unit_tb.sv
